// ----- rtl/srt_pkg.sv -----
// Shared types and constants for the sorted route table.
`timescale 1ns / 1ps

package srt_pkg;

  // Number of route slots, and the bits needed to name one of them
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths of the stream payloads
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 104;

  // Operation carried with each request
  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_GET    = 2'd3
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_ACT   = 2'd2,
    ST_INS   = 2'd3
  } state_e;

  // One route slot
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } entry_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic  capture;    // register the compare result for the pending request
    logic  remove;     // close the gap at the first marked cell
    logic  insert;     // open a gap at the first marked cell and load the request
    logic  ins_phase;  // mark cells by insert position instead of by compare hit
    mode_e mode;
  } cell_ctl_t;

endpackage

// ----- rtl/sorted_route_table_top.sv -----
// Top level of the sorted route table: request sequencer, cell row and result register.
//
//  Channel  | Dir | Contents
//  s_axis   | in  | tuser: mode; tdata: address, mask, gateway, port_id (from bit 0 up)
//  m_axis   | out | tuser: status; tdata: entry_index, route_address, route_mask,
//           |     |        route_gateway, route_port (from bit 0 up)
//
// One request at a time. Lookup, get and delete go through accept, compare and act,
// and their result is written to the result register in the act step; add goes through
// accept, compare, remove same destination and insert, and writes it in the insert step.
// Each step is one pass of the compare and priority chain across the cell row.
// Reset empties the table at once by clearing every slot.
// A stalled result holds the sequencer; no new request is taken until it has
// been written to the result register.
`timescale 1ns / 1ps

module sorted_route_table_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // mode
  input  logic [103:0] s_axis_tdata,   // address, mask, gateway, port_id, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [1:0]   m_axis_tuser,   // status
  output logic [103:0] m_axis_tdata    // entry_index, route_address, route_mask,
                                       // route_gateway, route_port
);

  localparam int unsigned D = srt_pkg::TABLE_DEPTH;

  srt_pkg::state_e    state_q, state_d;
  srt_pkg::mode_e     mode_q;
  srt_pkg::entry_t    req_q;
  srt_pkg::cell_ctl_t ctl;

  srt_pkg::entry_t entry_w [D];
  logic [D:0]      chain_w;
  logic [D-1:0]    first_w;

  srt_pkg::entry_t          sel_entry;
  logic [srt_pkg::IDX_W-1:0] sel_idx;
  logic                     found;
  logic                     full;

  logic                            out_valid_q;
  logic [srt_pkg::STATUS_W-1:0]    out_user_q, out_user_d;
  logic [srt_pkg::OUT_DATA_W-1:0]  out_data_q, out_data_d;
  logic                            out_load;
  logic                            out_free;
  logic                            accept;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q        <= srt_pkg::mode_e'(s_axis_tuser);
      req_q.valid   <= 1'b1;
      req_q.address <= s_axis_tdata[31:0];
      req_q.mask    <= s_axis_tdata[63:32];
      req_q.gateway <= s_axis_tdata[95:64];
      req_q.port    <= s_axis_tdata[99:96];
    end
  end

  // Row of cells, chained by neighbour data and the marked-before flag
  assign chain_w[0] = 1'b0;
  for (genvar i = 0; i < D; i++) begin : g_cell
    srt_pkg::entry_t prev_e, next_e;
    if (i == 0) begin : g_head
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = entry_w[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = entry_w[i+1];
    end
    srt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .req_i    (req_q),
      .prev_i   (prev_e),
      .next_i   (next_e),
      .before_i (chain_w[i]),
      .after_o  (chain_w[i+1]),
      .first_o  (first_w[i]),
      .entry_o  (entry_w[i])
    );
  end

  assign found = chain_w[D];
  assign full  = entry_w[D-1].valid;

  // Pick the first marked slot and its index
  always_comb begin
    sel_entry = '0;
    sel_idx   = '0;
    for (int i = 0; i < D; i++) begin
      sel_entry = srt_pkg::entry_t'(sel_entry |
                  (entry_w[i] & {$bits(srt_pkg::entry_t){first_w[i]}}));
      if (first_w[i]) begin
        sel_idx = sel_idx | srt_pkg::IDX_W'(i);
      end
    end
  end

  // Sequencer: next state, cell control and result
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    ctl           = '{capture: 1'b0, remove: 1'b0, insert: 1'b0,
                      ins_phase: 1'b0, mode: mode_q};
    out_load      = 1'b0;
    out_user_d    = srt_pkg::STATUS_OK;
    out_data_d    = '0;
    unique case (state_q)
      srt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = srt_pkg::ST_MATCH;
        end
      end
      srt_pkg::ST_MATCH: begin
        ctl.capture = 1'b1;
        state_d     = srt_pkg::ST_ACT;
      end
      srt_pkg::ST_ACT: begin
        if (mode_q == srt_pkg::MODE_ADD) begin
          // drop any route with the same destination first
          ctl.remove = 1'b1;
          state_d    = srt_pkg::ST_INS;
        end else if (out_free) begin
          ctl.remove = (mode_q == srt_pkg::MODE_DELETE);
          out_load   = 1'b1;
          out_user_d = found ? srt_pkg::STATUS_OK : srt_pkg::STATUS_NOT_FOUND;
          out_data_d = {sel_entry.port, sel_entry.gateway, sel_entry.mask,
                        sel_entry.address, srt_pkg::INDEX_W'(sel_idx)};
          state_d    = srt_pkg::ST_IDLE;
        end
      end
      srt_pkg::ST_INS: begin
        ctl.ins_phase = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = srt_pkg::ST_IDLE;
          if (full) begin
            out_user_d = srt_pkg::STATUS_FULL;
          end else begin
            ctl.insert = 1'b1;
            out_data_d = {req_q.port, req_q.gateway, req_q.mask, req_q.address,
                          srt_pkg::INDEX_W'(sel_idx)};
          end
        end
      end
      default: state_d = srt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register: hold until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_user_q <= out_user_d;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/srt_cell.sv -----
// One route slot of the table with its compare logic and neighbour shift.
`timescale 1ns / 1ps

module srt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srt_pkg::cell_ctl_t ctl_i,
  input  srt_pkg::entry_t   req_i,     // pending request as a route
  input  srt_pkg::entry_t   prev_i,    // slot above (lower index)
  input  srt_pkg::entry_t   next_i,    // slot below (higher index)
  input  logic              before_i,  // some earlier cell is marked
  output logic              after_o,   // this or some earlier cell is marked
  output logic              first_o,   // this is the first marked cell
  output srt_pkg::entry_t   entry_o
);

  srt_pkg::entry_t entry_q, entry_d;
  logic            hit_q, hit_d;
  logic            ins_here;
  logic            mark;

  // Compare the stored route against the request
  always_comb begin
    hit_d = hit_q;
    if (ctl_i.capture) begin
      case (ctl_i.mode)
        srt_pkg::MODE_LOOKUP: hit_d = (req_i.address & entry_q.mask) == entry_q.address;
        srt_pkg::MODE_GET:    hit_d = (entry_q.address == req_i.address) &&
                                      (entry_q.mask == req_i.mask);
        default:              hit_d = entry_q.address == req_i.address;
      endcase
      hit_d = hit_d & entry_q.valid;
    end
  end

  // Insert point: first empty slot or first mask not above the new one
  assign ins_here = !entry_q.valid || (entry_q.mask <= req_i.mask);
  assign mark     = ctl_i.ins_phase ? ins_here : hit_q;
  assign first_o  = mark && !before_i;
  assign after_o  = mark || before_i;

  // Shift up on removal, shift down or load on insertion, else hold
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.remove && (before_i || mark)) begin
      entry_d = next_i;
    end else if (ctl_i.insert) begin
      if (first_o) begin
        entry_d = req_i;
      end else if (before_i) begin
        entry_d = prev_i;
      end
    end
  end

  // Slot and compare flag, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      hit_q   <= hit_d;
    end
  end

  assign entry_o = entry_q;

endmodule
